[hw/rtl/sht_pkg.sv]
// Types and code constants for the sensor hysteresis bill tracker.
// No dependencies; used by the top level and the testbench.
`timescale 1ns / 1ps

package sht_pkg;

    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;

    localparam logic [LEVEL_W-1:0] LEVEL_NA = 8'd255;

    // shared class codes (2 and 3 bit variants)
    localparam logic [1:0] C_UNKNOWN = 2'd0;
    localparam logic [1:0] C_INVALID = 2'd1;
    localparam logic [1:0] C_LOW     = 2'd2;
    localparam logic [1:0] C_HIGH    = 2'd3;

    localparam logic [2:0] T_UNKNOWN = 3'd0;
    localparam logic [2:0] T_INVALID = 3'd1;
    localparam logic [2:0] T_UNDER   = 3'd2;
    localparam logic [2:0] T_WITHIN  = 3'd3;
    localparam logic [2:0] T_OVER    = 3'd4;

    localparam logic [1:0] SCAN_OCCUPIED = 2'd0;
    localparam logic [1:0] SCAN_EMPTY    = 2'd1;
    localparam logic [1:0] SCAN_UNKNOWN  = 2'd2;

    localparam logic [2:0] EV_NOT_PRESENT = 3'd0;
    localparam logic [2:0] EV_ENTERED     = 3'd1;
    localparam logic [2:0] EV_PRESENT     = 3'd2;
    localparam logic [2:0] EV_EXITED      = 3'd3;
    localparam logic [2:0] EV_FAULT       = 3'd4;
    localparam logic [2:0] EV_UNKNOWN     = 3'd5;

    // register indexes
    localparam logic [2:0] REG_VALID_MIN   = 3'd0;
    localparam logic [2:0] REG_VALID_MAX   = 3'd1;
    localparam logic [2:0] REG_NOMINAL_MIN = 3'd2;
    localparam logic [2:0] REG_NOMINAL_MAX = 3'd3;
    localparam logic [2:0] REG_LOW_THRESH  = 3'd4;
    localparam logic [2:0] REG_HIGH_THRESH = 3'd5;

    typedef struct packed {
        logic [LEVEL_W-1:0] thick_left_level;
        logic [LEVEL_W-1:0] thick_right_level;
        logic [LEVEL_W-1:0] feeder_level;
        logic [LEVEL_W-1:0] stacker_level;
        logic [LEVEL_W-1:0] uv_level;
        logic [LEVEL_W-1:0] mag_level;
    } t_frame;

    typedef struct packed {
        logic [2:0] thick_left_class;
        logic [2:0] thick_right_class;
        logic [1:0] feeder_class;
        logic [1:0] stacker_class;
        logic [1:0] uv_class;
        logic [1:0] mag_class;
        logic [1:0] detect_left_class;
        logic [1:0] detect_right_class;
        logic [1:0] scanner_state;
        logic [2:0] bill_event;
    } t_result;

endpackage

[hw/rtl/sht_stream_if.sv]
// Valid/ready stream interface carrying one payload (a request frame or a result).
// Payload type is given by the instantiating module, usually from sht_pkg.
`timescale 1ns / 1ps

interface sht_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/sensor_hysteresis_bill_tracker.sv]
// Sensor hysteresis bill tracker top level: APB threshold registers,
// input register, classification logic, result register. Uses sht_pkg, sht_stream_if.
// Path: input reg, then result reg; a stalled result keeps a full input reg, so i_req stalls.
// One request per cycle unless o_res stalls; the input register fills while a result waits.
// History state (previous classes, scanner state) updates as a request enters the result reg.
// Reset (i_rst_n, synchronous, active low): thresholds to defaults, history to unknown,
// both stages empty.
`timescale 1ns / 1ps

module sensor_hysteresis_bill_tracker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    sht_stream_if.sink                 i_req,
    sht_stream_if.source               o_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sht_pkg::ADDR_W-1:0] paddr,
    input  logic [sht_pkg::DATA_W-1:0] pwdata,
    output logic [sht_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [7:0] r_valid_min, r_valid_max, r_nominal_min, r_nominal_max;
    logic [7:0] r_low_thresh, r_high_thresh;

    logic             r_s1_valid;
    sht_pkg::t_frame  r_s1;
    logic             r_out_valid;
    sht_pkg::t_result r_out;

    logic [1:0] r_feeder_prev, r_stacker_prev, r_uv_prev, r_mag_prev;
    logic [1:0] r_det_l_prev, r_det_r_prev, r_scan_prev;

    logic             cfg_wr;
    logic [2:0]       cfg_idx;
    logic             advance;
    sht_pkg::t_result n_out;

    function automatic logic [2:0] window_class(
        input logic [7:0] v, input logic [7:0] vmin, input logic [7:0] vmax,
        input logic [7:0] nmin, input logic [7:0] nmax);
        logic [2:0] c;
        if (v == sht_pkg::LEVEL_NA)  c = sht_pkg::T_UNKNOWN;
        else if (v < vmin)           c = sht_pkg::T_INVALID;
        else if (v < nmin)           c = sht_pkg::T_UNDER;
        else if (v < nmax)           c = sht_pkg::T_WITHIN;
        else if (v < vmax)           c = sht_pkg::T_OVER;
        else                         c = sht_pkg::T_INVALID;
        return c;
    endfunction

    function automatic logic [1:0] hyst_class(
        input logic [7:0] v, input logic [1:0] prev, input logic [1:0] below_low,
        input logic [7:0] vmin, input logic [7:0] vmax,
        input logic [7:0] lo, input logic [7:0] hi);
        logic [1:0] above_high;
        logic [1:0] c;
        above_high = (below_low == sht_pkg::C_LOW) ? sht_pkg::C_HIGH : sht_pkg::C_LOW;
        if (v == sht_pkg::LEVEL_NA)  c = sht_pkg::C_UNKNOWN;
        else if (v < vmin)           c = sht_pkg::C_INVALID;
        else if (v < lo)             c = below_low;
        else if (v < hi)             c = (prev == above_high) ? above_high : below_low;
        else if (v < vmax)           c = above_high;
        else                         c = sht_pkg::C_INVALID;
        return c;
    endfunction

    // APB register file
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            sht_pkg::REG_VALID_MIN:   prdata[7:0] = r_valid_min;
            sht_pkg::REG_VALID_MAX:   prdata[7:0] = r_valid_max;
            sht_pkg::REG_NOMINAL_MIN: prdata[7:0] = r_nominal_min;
            sht_pkg::REG_NOMINAL_MAX: prdata[7:0] = r_nominal_max;
            sht_pkg::REG_LOW_THRESH:  prdata[7:0] = r_low_thresh;
            sht_pkg::REG_HIGH_THRESH: prdata[7:0] = r_high_thresh;
            default:                  prdata      = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_min   <= 8'd10;
            r_valid_max   <= 8'd90;
            r_nominal_min <= 8'd25;
            r_nominal_max <= 8'd75;
            r_low_thresh  <= 8'd30;
            r_high_thresh <= 8'd70;
        end else if (cfg_wr) begin
            case (cfg_idx)
                sht_pkg::REG_VALID_MIN:   r_valid_min   <= pwdata[7:0];
                sht_pkg::REG_VALID_MAX:   r_valid_max   <= pwdata[7:0];
                sht_pkg::REG_NOMINAL_MIN: r_nominal_min <= pwdata[7:0];
                sht_pkg::REG_NOMINAL_MAX: r_nominal_max <= pwdata[7:0];
                sht_pkg::REG_LOW_THRESH:  r_low_thresh  <= pwdata[7:0];
                sht_pkg::REG_HIGH_THRESH: r_high_thresh <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // two-stage pipe
    assign advance     = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_s1_valid || advance;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_comb begin
        n_out.thick_left_class  = window_class(r_s1.thick_left_level, r_valid_min,
            r_valid_max, r_nominal_min, r_nominal_max);
        n_out.thick_right_class = window_class(r_s1.thick_right_level, r_valid_min,
            r_valid_max, r_nominal_min, r_nominal_max);
        n_out.feeder_class  = hyst_class(r_s1.feeder_level, r_feeder_prev, sht_pkg::C_LOW,
            r_valid_min, r_valid_max, r_low_thresh, r_high_thresh);
        n_out.stacker_class = hyst_class(r_s1.stacker_level, r_stacker_prev, sht_pkg::C_HIGH,
            r_valid_min, r_valid_max, r_low_thresh, r_high_thresh);
        n_out.uv_class      = hyst_class(r_s1.uv_level, r_uv_prev, sht_pkg::C_LOW,
            r_valid_min, r_valid_max, r_low_thresh, r_high_thresh);
        n_out.mag_class     = hyst_class(r_s1.mag_level, r_mag_prev, sht_pkg::C_LOW,
            r_valid_min, r_valid_max, r_low_thresh, r_high_thresh);
        n_out.detect_left_class  = hyst_class(r_s1.thick_left_level, r_det_l_prev,
            sht_pkg::C_LOW, r_valid_min, r_valid_max, r_low_thresh, r_high_thresh);
        n_out.detect_right_class = hyst_class(r_s1.thick_right_level, r_det_r_prev,
            sht_pkg::C_LOW, r_valid_min, r_valid_max, r_low_thresh, r_high_thresh);

        if (n_out.detect_left_class == sht_pkg::C_LOW ||
            n_out.detect_right_class == sht_pkg::C_LOW)
            n_out.scanner_state = sht_pkg::SCAN_OCCUPIED;
        else if (n_out.detect_left_class == sht_pkg::C_HIGH &&
                 n_out.detect_right_class == sht_pkg::C_HIGH)
            n_out.scanner_state = sht_pkg::SCAN_EMPTY;
        else
            n_out.scanner_state = sht_pkg::SCAN_UNKNOWN;

        case (n_out.scanner_state)
            sht_pkg::SCAN_EMPTY: n_out.bill_event = (r_scan_prev == sht_pkg::SCAN_OCCUPIED)
                ? sht_pkg::EV_EXITED : sht_pkg::EV_NOT_PRESENT;
            sht_pkg::SCAN_OCCUPIED: n_out.bill_event = (r_scan_prev == sht_pkg::SCAN_EMPTY)
                ? sht_pkg::EV_ENTERED : sht_pkg::EV_PRESENT;
            default: n_out.bill_event = (r_scan_prev != sht_pkg::SCAN_UNKNOWN)
                ? sht_pkg::EV_FAULT : sht_pkg::EV_UNKNOWN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_feeder_prev  <= sht_pkg::C_UNKNOWN;
            r_stacker_prev <= sht_pkg::C_UNKNOWN;
            r_uv_prev      <= sht_pkg::C_UNKNOWN;
            r_mag_prev     <= sht_pkg::C_UNKNOWN;
            r_det_l_prev   <= sht_pkg::C_UNKNOWN;
            r_det_r_prev   <= sht_pkg::C_UNKNOWN;
            r_scan_prev    <= sht_pkg::SCAN_UNKNOWN;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid    <= 1'b1;
                r_feeder_prev  <= n_out.feeder_class;
                r_stacker_prev <= n_out.stacker_class;
                r_uv_prev      <= n_out.uv_class;
                r_mag_prev     <= n_out.mag_class;
                r_det_l_prev   <= n_out.detect_left_class;
                r_det_r_prev   <= n_out.detect_right_class;
                r_scan_prev    <= n_out.scanner_state;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_s1 <= i_req.data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    a_occupied_needs_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.scanner_state == sht_pkg::SCAN_OCCUPIED |->
            r_out.detect_left_class == sht_pkg::C_LOW ||
            r_out.detect_right_class == sht_pkg::C_LOW)
        else $error("occupied scanner without a blocked detector");

    a_history_tracks_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_scan_prev == r_out.scanner_state &&
            r_det_l_prev == r_out.detect_left_class)
        else $error("history registers out of step with result register");

    a_stage_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !o_res.ready |=> r_s1_valid && r_out_valid)
        else $error("request dropped under back-pressure");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> i_req.ready)
        else $error("input stalled with empty input register");

endmodule

[test/testbench.sv]
// Testbench for sensor_hysteresis_bill_tracker: directed frames, then bill passages and
// noise under several threshold settings, each result checked against a local predictor.
// Depends on sht_pkg, sht_stream_if and the tracker RTL.
`timescale 1ns / 1ps

module testbench;

    typedef enum {
        LV_NA, LV_UNDER_VALID, LV_LOW, LV_BAND, LV_HIGH, LV_OVER_VALID, LV_ANY
    } t_lvl_kind;

    // register indexes past the implemented set; writes there must be dropped
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;
    localparam int PHASE_FRAMES = 80;
    localparam int DRAIN_LIMIT  = 10000;

    class bill_scoreboard;
        logic [7:0]        thresh [6];
        logic [1:0]        feeder_hist, stacker_hist, uv_hist, mag_hist;
        logic [1:0]        left_hist, right_hist, scan_hist;
        sht_pkg::t_result  pending [$];
        int                n_checked, n_bad, n_orphan, n_reported;
        int                ev_count [6];

        function new();
            thresh = '{8'd10, 8'd90, 8'd25, 8'd75, 8'd30, 8'd70};
            feeder_hist  = sht_pkg::C_UNKNOWN;
            stacker_hist = sht_pkg::C_UNKNOWN;
            uv_hist      = sht_pkg::C_UNKNOWN;
            mag_hist     = sht_pkg::C_UNKNOWN;
            left_hist    = sht_pkg::C_UNKNOWN;
            right_hist   = sht_pkg::C_UNKNOWN;
            scan_hist    = sht_pkg::SCAN_UNKNOWN;
            n_checked    = 0;
            n_bad        = 0;
            n_orphan     = 0;
            n_reported   = 0;
            foreach (ev_count[i]) ev_count[i] = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [7:0] val);
            if (idx <= sht_pkg::REG_HIGH_THRESH) thresh[idx] = val;
        endfunction

        function logic [2:0] window_of(logic [7:0] lv);
            if (lv == sht_pkg::LEVEL_NA) return sht_pkg::T_UNKNOWN;
            if (lv < thresh[sht_pkg::REG_VALID_MIN]) return sht_pkg::T_INVALID;
            if (lv < thresh[sht_pkg::REG_NOMINAL_MIN]) return sht_pkg::T_UNDER;
            if (lv < thresh[sht_pkg::REG_NOMINAL_MAX]) return sht_pkg::T_WITHIN;
            if (lv < thresh[sht_pkg::REG_VALID_MAX]) return sht_pkg::T_OVER;
            return sht_pkg::T_INVALID;
        endfunction

        function logic [1:0] hyst_of(logic [7:0] lv, logic [1:0] hist, logic [1:0] low_side);
            logic [1:0] high_side;
            high_side = (low_side == sht_pkg::C_LOW) ? sht_pkg::C_HIGH : sht_pkg::C_LOW;
            if (lv == sht_pkg::LEVEL_NA) return sht_pkg::C_UNKNOWN;
            if (lv < thresh[sht_pkg::REG_VALID_MIN]) return sht_pkg::C_INVALID;
            if (lv < thresh[sht_pkg::REG_LOW_THRESH]) return low_side;
            if (lv < thresh[sht_pkg::REG_HIGH_THRESH])
                return (hist == high_side) ? high_side : low_side;
            if (lv < thresh[sht_pkg::REG_VALID_MAX]) return high_side;
            return sht_pkg::C_INVALID;
        endfunction

        function void note_request(sht_pkg::t_frame f);
            sht_pkg::t_result e;
            e.thick_left_class   = window_of(f.thick_left_level);
            e.thick_right_class  = window_of(f.thick_right_level);
            e.feeder_class       = hyst_of(f.feeder_level, feeder_hist, sht_pkg::C_LOW);
            e.stacker_class      = hyst_of(f.stacker_level, stacker_hist, sht_pkg::C_HIGH);
            e.uv_class           = hyst_of(f.uv_level, uv_hist, sht_pkg::C_LOW);
            e.mag_class          = hyst_of(f.mag_level, mag_hist, sht_pkg::C_LOW);
            e.detect_left_class  = hyst_of(f.thick_left_level, left_hist, sht_pkg::C_LOW);
            e.detect_right_class = hyst_of(f.thick_right_level, right_hist, sht_pkg::C_LOW);
            if (e.detect_left_class == sht_pkg::C_LOW ||
                e.detect_right_class == sht_pkg::C_LOW)
                e.scanner_state = sht_pkg::SCAN_OCCUPIED;
            else if (e.detect_left_class == sht_pkg::C_HIGH &&
                     e.detect_right_class == sht_pkg::C_HIGH)
                e.scanner_state = sht_pkg::SCAN_EMPTY;
            else
                e.scanner_state = sht_pkg::SCAN_UNKNOWN;
            if (e.scanner_state == sht_pkg::SCAN_EMPTY)
                e.bill_event = (scan_hist == sht_pkg::SCAN_OCCUPIED)
                    ? sht_pkg::EV_EXITED : sht_pkg::EV_NOT_PRESENT;
            else if (e.scanner_state == sht_pkg::SCAN_OCCUPIED)
                e.bill_event = (scan_hist == sht_pkg::SCAN_EMPTY)
                    ? sht_pkg::EV_ENTERED : sht_pkg::EV_PRESENT;
            else
                e.bill_event = (scan_hist != sht_pkg::SCAN_UNKNOWN)
                    ? sht_pkg::EV_FAULT : sht_pkg::EV_UNKNOWN;
            feeder_hist  = e.feeder_class;
            stacker_hist = e.stacker_class;
            uv_hist      = e.uv_class;
            mag_hist     = e.mag_class;
            left_hist    = e.detect_left_class;
            right_hist   = e.detect_right_class;
            scan_hist    = e.scanner_state;
            pending.push_back(e);
        endfunction

        function string show(sht_pkg::t_result r);
            return $sformatf({"tl=%0d tr=%0d fd=%0d st=%0d uv=%0d mg=%0d ",
                              "dl=%0d dr=%0d scan=%0d ev=%0d"},
                r.thick_left_class, r.thick_right_class, r.feeder_class, r.stacker_class,
                r.uv_class, r.mag_class, r.detect_left_class, r.detect_right_class,
                r.scanner_state, r.bill_event);
        endfunction

        function void check_result(sht_pkg::t_result r);
            sht_pkg::t_result e;
            if (pending.size() == 0) begin
                n_orphan++;
                if (n_reported < 10) begin
                    n_reported++;
                    $display("ERROR: result with no request outstanding: %s", show(r));
                end
                return;
            end
            e = pending.pop_front();
            n_checked++;
            ev_count[e.bill_event]++;
            if (r.thick_left_class !== e.thick_left_class ||
                r.thick_right_class !== e.thick_right_class ||
                r.feeder_class !== e.feeder_class ||
                r.stacker_class !== e.stacker_class ||
                r.uv_class !== e.uv_class ||
                r.mag_class !== e.mag_class ||
                r.detect_left_class !== e.detect_left_class ||
                r.detect_right_class !== e.detect_right_class ||
                r.scanner_state !== e.scanner_state ||
                r.bill_event !== e.bill_event) begin
                n_bad++;
                if (n_reported < 10) begin
                    n_reported++;
                    $display("ERROR: result %0d mismatch", n_checked);
                    $display("  expected %s", show(e));
                    $display("  actual   %s", show(r));
                end
            end
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [sht_pkg::ADDR_W-1:0]   paddr;
    logic [sht_pkg::DATA_W-1:0]   pwdata;
    logic [sht_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    sht_stream_if #(.T(sht_pkg::t_frame))  req_if ();
    sht_stream_if #(.T(sht_pkg::t_result)) res_if ();

    bill_scoreboard sb;
    bit source_idle;
    bit sink_idle;
    int sink_stall;
    int frames_sent;
    int settings_used;
    int n_fail;

    sensor_hysteresis_bill_tracker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Timeout after %0d frames", frames_sent);
        $display("Some tests failed");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(99, 0);
        if (r < 60) return $urandom_range(2, 1);
        if (r < 92) return $urandom_range(8, 3);
        return $urandom_range(50, 15);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            sink_stall = 0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            res_if.ready <= 1'b0;
        end else if (sink_idle && $urandom_range(99, 0) < 30) begin
            sink_stall = idle_len() - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) sb.note_request(req_if.data);
            if (res_if.valid && res_if.ready) sb.check_result(res_if.data);
        end
    end

    function automatic logic [7:0] level_of(t_lvl_kind k);
        int lo;
        int hi;
        case (k)
            LV_NA: return sht_pkg::LEVEL_NA;
            LV_UNDER_VALID: begin
                lo = 0;
                hi = int'(sb.thresh[sht_pkg::REG_VALID_MIN]) - 1;
            end
            LV_LOW: begin
                lo = int'(sb.thresh[sht_pkg::REG_VALID_MIN]);
                hi = int'(sb.thresh[sht_pkg::REG_LOW_THRESH]) - 1;
            end
            LV_BAND: begin
                lo = int'(sb.thresh[sht_pkg::REG_LOW_THRESH]);
                hi = int'(sb.thresh[sht_pkg::REG_HIGH_THRESH]) - 1;
            end
            LV_HIGH: begin
                lo = int'(sb.thresh[sht_pkg::REG_HIGH_THRESH]);
                hi = int'(sb.thresh[sht_pkg::REG_VALID_MAX]) - 1;
            end
            LV_OVER_VALID: begin
                lo = int'(sb.thresh[sht_pkg::REG_VALID_MAX]);
                hi = 254;
            end
            default: return 8'($urandom_range(255, 0));
        endcase
        if (lo > hi) return 8'($urandom_range(254, 0));
        return 8'($urandom_range(hi, lo));
    endfunction

    function automatic t_lvl_kind aux_kind();
        int r;
        r = $urandom_range(99, 0);
        if (r < 5) return LV_NA;
        if (r < 10) return LV_UNDER_VALID;
        if (r < 35) return LV_LOW;
        if (r < 65) return LV_BAND;
        if (r < 90) return LV_HIGH;
        if (r < 95) return LV_OVER_VALID;
        return LV_ANY;
    endfunction

    function automatic t_lvl_kind low_or_band();
        return ($urandom_range(1, 0) == 1) ? LV_LOW : LV_BAND;
    endfunction

    function automatic sht_pkg::t_frame mk_frame(logic [7:0] tl, logic [7:0] tr,
                                                 logic [7:0] fd, logic [7:0] st,
                                                 logic [7:0] uv, logic [7:0] mg);
        sht_pkg::t_frame f;
        f.thick_left_level  = tl;
        f.thick_right_level = tr;
        f.feeder_level      = fd;
        f.stacker_level     = st;
        f.uv_level          = uv;
        f.mag_level         = mg;
        return f;
    endfunction

    function automatic logic [7:0] rnd_level();
        return 8'($urandom_range(255, 0));
    endfunction

    task automatic send_frame(sht_pkg::t_frame f);
        int gap;
        gap = (source_idle && $urandom_range(99, 0) < 45) ? idle_len() : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= f;
        do @(posedge i_clk); while (!req_if.ready);
        frames_sent++;
    endtask

    // the first edge lets the monitor note a request accepted at the calling edge
    task automatic wait_drain();
        int guard;
        guard = 0;
        req_if.valid <= 1'b0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (sb.pending.size() != 0 && guard < DRAIN_LIMIT);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom_range(32'hFF_FFFF, 0)), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic apply_setting(logic [7:0] vmin, logic [7:0] vmax, logic [7:0] nmin,
                                 logic [7:0] nmax, logic [7:0] lo, logic [7:0] hi);
        write_cfg(sht_pkg::REG_VALID_MIN, vmin);
        write_cfg(sht_pkg::REG_VALID_MAX, vmax);
        write_cfg(sht_pkg::REG_NOMINAL_MIN, nmin);
        write_cfg(sht_pkg::REG_NOMINAL_MAX, nmax);
        write_cfg(sht_pkg::REG_LOW_THRESH, lo);
        write_cfg(sht_pkg::REG_HIGH_THRESH, hi);
        settings_used++;
    endtask

    task automatic send_scene(t_lvl_kind left, t_lvl_kind right);
        sht_pkg::t_frame f;
        // occasionally break the passage with a stray detector reading
        if ($urandom_range(99, 0) < 6) left = aux_kind();
        if ($urandom_range(99, 0) < 6) right = aux_kind();
        f.thick_left_level  = level_of(left);
        f.thick_right_level = level_of(right);
        f.feeder_level      = level_of(aux_kind());
        f.stacker_level     = level_of(aux_kind());
        f.uv_level          = level_of(aux_kind());
        f.mag_level         = level_of(aux_kind());
        send_frame(f);
    endtask

    task automatic bill_passage();
        repeat ($urandom_range(3, 1)) send_scene(LV_HIGH, ($urandom_range(1, 0) == 1) ? LV_HIGH
                                                                                      : LV_BAND);
        send_scene(LV_LOW, LV_HIGH);
        repeat ($urandom_range(4, 1)) send_scene(low_or_band(), low_or_band());
        send_scene(($urandom_range(1, 0) == 1) ? LV_BAND : LV_HIGH, LV_LOW);
        send_scene(LV_HIGH, LV_HIGH);
        if ($urandom_range(1, 0) == 1) send_scene(LV_BAND, LV_BAND);
    endtask

    task automatic send_noise();
        if ($urandom_range(1, 0) == 1)
            send_frame(mk_frame(rnd_level(), rnd_level(), rnd_level(),
                                rnd_level(), rnd_level(), rnd_level()));
        else
            send_scene(aux_kind(), aux_kind());
    endtask

    task automatic random_phase(int quota);
        int start;
        start = frames_sent;
        while (frames_sent - start < quota) begin
            source_idle = ($urandom_range(99, 0) >= 20);
            sink_idle   = ($urandom_range(99, 0) >= 20);
            if ($urandom_range(99, 0) < 70)
                bill_passage();
            else
                repeat ($urandom_range(5, 1)) send_noise();
        end
        wait_drain();
    endtask

    task automatic ordered_setting();
        int vmin, nmin, lo, hi, nmax, vmax;
        vmin = $urandom_range(40, 0);
        nmin = vmin + $urandom_range(30, 0);
        lo   = nmin + $urandom_range(30, 0);
        hi   = lo + $urandom_range(60, 1);
        nmax = hi + $urandom_range(30, 0);
        vmax = nmax + $urandom_range(40, 1);
        apply_setting(8'(vmin), 8'(vmax), 8'(nmin), 8'(nmax), 8'(lo), 8'(hi));
    endtask

    initial begin
        sb = new();
        i_rst_n      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        source_idle   = 1'b1;
        sink_idle     = 1'b1;
        frames_sent   = 0;
        settings_used = 1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset thresholds: boundaries, unavailable levels and every scanner transition
        send_frame(mk_frame(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
        send_frame(mk_frame(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_frame(mk_frame(8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9));
        send_frame(mk_frame(8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10));
        send_frame(mk_frame(8'd24, 8'd25, 8'd29, 8'd30, 8'd69, 8'd70));
        send_frame(mk_frame(8'd74, 8'd75, 8'd80, 8'd80, 8'd80, 8'd80));
        send_frame(mk_frame(8'd50, 8'd50, 8'd50, 8'd50, 8'd50, 8'd50));
        send_frame(mk_frame(8'd89, 8'd89, 8'd89, 8'd89, 8'd89, 8'd89));
        send_frame(mk_frame(8'd20, 8'd80, 8'd30, 8'd69, 8'd30, 8'd69));
        send_frame(mk_frame(8'd50, 8'd50, 8'd69, 8'd30, 8'd69, 8'd30));
        send_frame(mk_frame(8'd80, 8'd80, 8'd90, 8'd90, 8'd254, 8'd254));
        send_frame(mk_frame(8'd90, 8'd90, 8'd50, 8'd50, 8'd50, 8'd50));
        send_frame(mk_frame(8'd254, 8'd254, 8'd20, 8'd20, 8'd20, 8'd20));
        send_frame(mk_frame(8'd20, 8'd255, 8'd70, 8'd70, 8'd70, 8'd70));
        send_frame(mk_frame(8'd80, 8'd255, 8'd50, 8'd50, 8'd50, 8'd50));
        send_frame(mk_frame(8'd80, 8'd80, 8'd255, 8'd0, 8'd128, 8'd127));
        send_frame(mk_frame(8'd255, 8'd20, 8'd1, 8'd2, 8'd4, 8'd8));
        send_frame(mk_frame(8'd69, 8'd70, 8'd16, 8'd32, 8'd64, 8'd85));
        send_frame(mk_frame(8'd30, 8'd29, 8'd170, 8'd240, 8'd15, 8'd60));
        send_frame(mk_frame(8'd70, 8'd70, 8'd31, 8'd71, 8'd11, 8'd76));
        send_frame(mk_frame(8'd30, 8'd69, 8'd45, 8'd45, 8'd45, 8'd45));
        send_frame(mk_frame(8'd29, 8'd0, 8'd100, 8'd200, 8'd150, 8'd251));
        wait_drain();

        // writes past the last register must leave the thresholds alone
        write_cfg(REG_SPARE_A, 8'd0);
        write_cfg(REG_SPARE_B, 8'd255);
        random_phase(PHASE_FRAMES);

        apply_setting(8'd5, 8'd200, 8'd40, 8'd150, 8'd60, 8'd120);
        random_phase(PHASE_FRAMES);
        apply_setting(8'd0, 8'd254, 8'd0, 8'd254, 8'd0, 8'd254);
        random_phase(PHASE_FRAMES);
        apply_setting(8'd254, 8'd0, 8'd254, 8'd0, 8'd254, 8'd0);
        random_phase(PHASE_FRAMES);
        apply_setting(8'd0, 8'd254, 8'd1, 8'd253, 8'd1, 8'd253);
        random_phase(PHASE_FRAMES);
        ordered_setting();
        random_phase(PHASE_FRAMES);
        ordered_setting();
        random_phase(PHASE_FRAMES);
        apply_setting(8'($urandom_range(254, 0)), 8'($urandom_range(254, 0)),
                      8'($urandom_range(254, 0)), 8'($urandom_range(254, 0)),
                      8'($urandom_range(254, 0)), 8'($urandom_range(254, 0)));
        random_phase(PHASE_FRAMES);

        wait_drain();
        repeat (4) @(posedge i_clk);

        if (sb.pending.size() != 0)
            $display("ERROR: %0d results never arrived", sb.pending.size());
        n_fail = sb.n_bad + sb.n_orphan + sb.pending.size();
        $display("Run covered %0d frames under %0d threshold settings, %0d results checked",
                 frames_sent, settings_used, sb.n_checked);
        $display("Events: %0d entered, %0d present, %0d exited, %0d none, %0d fault, %0d unknown",
                 sb.ev_count[sht_pkg::EV_ENTERED], sb.ev_count[sht_pkg::EV_PRESENT],
                 sb.ev_count[sht_pkg::EV_EXITED], sb.ev_count[sht_pkg::EV_NOT_PRESENT],
                 sb.ev_count[sht_pkg::EV_FAULT], sb.ev_count[sht_pkg::EV_UNKNOWN]);
        if (n_fail == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[sensor_hysteresis_bill_tracker.f]
hw/rtl/sht_pkg.sv
hw/rtl/sht_stream_if.sv
hw/rtl/sensor_hysteresis_bill_tracker.sv
test/testbench.sv
